// ===== hdl/mcadc_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the ADC median filter.
package mcadc_pkg;

  localparam int CHANNEL_COUNT_DEF    = 8;
  localparam int RING_DEPTH_DEF       = 5;
  localparam int OVERSAMPLE_SHIFT_DEF = 2;

  localparam int FUNC_W     = 2;
  localparam int CH_FIELD_W = 4;
  localparam int RAW_W      = 16;
  localparam int ADC_LSB    = 4;
  localparam int ADC_W      = 12;
  localparam int MEDIAN_W   = 16;

  localparam int CH_LSB  = 0;
  localparam int RAW_LSB = CH_LSB + CH_FIELD_W;

  localparam int S_TDATA_W = 24;
  localparam int S_TUSER_W = FUNC_W;
  localparam int M_TDATA_W = MEDIAN_W;
  localparam int M_TUSER_W = 1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_STORE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_t;

  typedef struct packed {
    logic capture;
    logic store;
    logic clear;
    logic fetch_start;
    logic fetch;
    logic load_out;
    logic res_ok;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  ch_valid;
    logic  full;
    logic  idx_last;
    logic  out_free;
  } sts_t;

endpackage

// ===== hdl/mcadc_ctrl.sv =====
// Controller state machine that sequences store, clear and median read transactions.
module mcadc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  mcadc_pkg::sts_t sts,
  output mcadc_pkg::cmd_t cmd
);
  import mcadc_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    DECIDE,
    FETCH,
    LAST,
    RESULT
  } state_t;

  state_t state;
  logic   res_ok;
  logic   go;
  logic   is_read;

  assign is_read = (sts.func == FUNC_READ);
  assign go      = is_read && sts.ch_valid && sts.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      res_ok <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            state <= DECIDE;
          end
        end
        DECIDE: begin
          res_ok <= go;
          if (go) begin
            state <= FETCH;
          end else if (is_read) begin
            state <= RESULT;
          end else begin
            state <= IDLE;
          end
        end
        FETCH: begin
          if (sts.idx_last) begin
            state <= LAST;
          end
        end
        LAST: begin
          state <= RESULT;
        end
        RESULT: begin
          if (sts.out_free) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd      = '0;
    s_tready = (state == IDLE);
    case (state)
      IDLE: begin
        cmd.capture = s_tvalid;
      end
      DECIDE: begin
        cmd.store       = (sts.func == FUNC_STORE) && sts.ch_valid;
        cmd.clear       = (sts.func == FUNC_CLEAR) && sts.ch_valid;
        cmd.fetch_start = go;
      end
      FETCH: begin
        cmd.fetch = 1'b1;
      end
      RESULT: begin
        cmd.load_out = sts.out_free;
        cmd.res_ok   = res_ok;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== hdl/mcadc_dp.sv =====
// Datapath with the sample ring memory, per-channel pointers, insertion sorter and output register.
module mcadc_dp #(
  parameter int CHANNEL_COUNT    = mcadc_pkg::CHANNEL_COUNT_DEF,
  parameter int RING_DEPTH       = mcadc_pkg::RING_DEPTH_DEF,
  parameter int OVERSAMPLE_SHIFT = mcadc_pkg::OVERSAMPLE_SHIFT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [mcadc_pkg::S_TDATA_W-1:0]  s_tdata,
  input  logic [mcadc_pkg::S_TUSER_W-1:0]  s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [mcadc_pkg::M_TDATA_W-1:0]  m_tdata,
  output logic [mcadc_pkg::M_TUSER_W-1:0]  m_tuser,
  input  mcadc_pkg::cmd_t                  cmd,
  output mcadc_pkg::sts_t                  sts
);
  import mcadc_pkg::*;

  localparam int SMP_W   = ADC_W + OVERSAMPLE_SHIFT;
  localparam int ENTRIES = CHANNEL_COUNT * RING_DEPTH;
  localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int POS_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W   = $clog2(RING_DEPTH + 1);
  localparam int CH_W    = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int MID     = RING_DEPTH / 2;

  func_t                 item_func;
  logic [CH_FIELD_W-1:0] item_ch;
  logic [RAW_W-1:0]      item_raw;

  logic [POS_W-1:0] pos  [CHANNEL_COUNT];
  logic [CNT_W-1:0] fill [CHANNEL_COUNT];

  logic [SMP_W-1:0] ring [ENTRIES];
  logic [SMP_W-1:0] rd_data;
  logic [POS_W-1:0] idx;
  logic             ins_en;
  logic [CNT_W-1:0] n;
  logic [SMP_W-1:0] sorted     [RING_DEPTH];
  logic [SMP_W-1:0] sorted_ins [RING_DEPTH];
  logic [RING_DEPTH-1:0] gt;

  logic             out_valid;
  logic             out_ok;
  logic [SMP_W-1:0] out_med;

  logic             ch_ok;
  logic [CH_W-1:0]  ch_sel;
  logic [POS_W-1:0] cur_pos;
  logic [CNT_W-1:0] cur_fill;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [SMP_W-1:0] smp;

  assign ch_ok    = {1'b0, item_ch} < (CH_FIELD_W + 1)'(CHANNEL_COUNT);
  assign ch_sel   = item_ch[CH_W-1:0];
  assign cur_pos  = pos[ch_sel];
  assign cur_fill = fill[ch_sel];
  assign base     = ADDR_W'(ch_sel * RING_DEPTH);
  assign wr_addr  = base + ADDR_W'(cur_pos);
  assign rd_addr  = base + ADDR_W'(idx);
  assign smp      = SMP_W'(item_raw[ADC_LSB +: ADC_W]) << OVERSAMPLE_SHIFT;

  assign sts.func     = item_func;
  assign sts.ch_valid = ch_ok;
  assign sts.full     = (cur_fill == CNT_W'(RING_DEPTH));
  assign sts.idx_last = (idx == POS_W'(RING_DEPTH - 1));
  assign sts.out_free = !out_valid || m_tready;

  // Slots at or beyond the fill level act as larger than any sample.
  always_comb begin
    for (int p = 0; p < RING_DEPTH; p++) begin
      gt[p] = (CNT_W'(p) >= n) || (sorted[p] > rd_data);
    end
    sorted_ins[0] = gt[0] ? rd_data : sorted[0];
    for (int p = 1; p < RING_DEPTH; p++) begin
      if (!gt[p]) begin
        sorted_ins[p] = sorted[p];
      end else if (gt[p-1]) begin
        sorted_ins[p] = sorted[p-1];
      end else begin
        sorted_ins[p] = rd_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_func <= func_t'(s_tuser);
      item_ch   <= s_tdata[CH_LSB +: CH_FIELD_W];
      item_raw  <= s_tdata[RAW_LSB +: RAW_W];
    end
    if (ins_en) begin
      sorted <= sorted_ins;
    end
    if (cmd.fetch_start) begin
      idx <= '0;
    end else if (cmd.fetch) begin
      idx <= idx + 1'b1;
    end
    if (cmd.load_out) begin
      out_ok  <= cmd.res_ok;
      out_med <= cmd.res_ok ? sorted[MID] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      ring[wr_addr] <= smp;
    end
    if (cmd.fetch) begin
      rd_data <= ring[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
        pos[c]  <= '0;
        fill[c] <= '0;
      end
      ins_en    <= 1'b0;
      n         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.store) begin
        pos[ch_sel] <= (cur_pos == POS_W'(RING_DEPTH - 1)) ? '0 : cur_pos + 1'b1;
        if (cur_fill != CNT_W'(RING_DEPTH)) begin
          fill[ch_sel] <= cur_fill + 1'b1;
        end
      end else if (cmd.clear) begin
        pos[ch_sel]  <= '0;
        fill[ch_sel] <= '0;
      end
      ins_en <= cmd.fetch;
      if (cmd.fetch_start) begin
        n <= '0;
      end else if (ins_en) begin
        n <= n + 1'b1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = M_TDATA_W'(out_med);
  assign m_tuser  = out_ok;

endmodule

// ===== hdl/multichannel_adc_median_filter_core.sv =====
// Top level of the per-channel ADC median filter.
//
//   Group   Dir   tdata (lowest bit up)              tuser
//   s_*     in    channel[3:0], raw_value[19:4]      func[1:0]
//   m_*     out   median[15:0]                       ready_res[0]
//
// A store or clear transaction passes through IDLE and DECIDE; a read that answers not-ready also passes RESULT.
// A read on a full ring also steps through FETCH and LAST, paced by the single ring read port
// that delivers one sample per cycle into the insertion sorter.
// Reset clears every write position and fill count; ring contents stay undefined.
// The result sits in an output register, so the next transaction is taken while it waits;
// only a read that finishes while the previous result is still held waits for m_tready.
module multichannel_adc_median_filter_core #(
  parameter int CHANNEL_COUNT    = mcadc_pkg::CHANNEL_COUNT_DEF,
  parameter int RING_DEPTH       = mcadc_pkg::RING_DEPTH_DEF,
  parameter int OVERSAMPLE_SHIFT = mcadc_pkg::OVERSAMPLE_SHIFT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [mcadc_pkg::S_TDATA_W-1:0] s_tdata,  // channel, raw_value, zero pad
  input  logic [mcadc_pkg::S_TUSER_W-1:0] s_tuser,  // func
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [mcadc_pkg::M_TDATA_W-1:0] m_tdata,  // median
  output logic [mcadc_pkg::M_TUSER_W-1:0] m_tuser   // ready_res
);
  import mcadc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mcadc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mcadc_dp #(
    .CHANNEL_COUNT    (CHANNEL_COUNT),
    .RING_DEPTH       (RING_DEPTH),
    .OVERSAMPLE_SHIFT (OVERSAMPLE_SHIFT)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

// ===== hdl/mcadc_chk.sv =====
// Port-level checker for the ADC median filter, bound to the top level.
module mcadc_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [mcadc_pkg::S_TUSER_W-1:0] s_tuser,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [mcadc_pkg::M_TDATA_W-1:0] m_tdata,
  input logic [mcadc_pkg::M_TUSER_W-1:0] m_tuser
);
  import mcadc_pkg::*;

  // A result transaction held back by the sink keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("Output changed while stalled.");

  // A not-ready result always carries a zero median.
  a_notready_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("Not-ready result with nonzero median.");

  // Only one transaction is in flight at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("Input taken twice in a row.");

  // Anything other than a read is finished once its DECIDE state has passed, with s_tready high again.
  a_quick_return: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser != FUNC_READ) |=> ##1 s_tready)
    else $error("Non-read transaction did not return to idle.");

endmodule

bind multichannel_adc_median_filter_core mcadc_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== tb/tb.sv =====
// Testbench for the per-channel ADC median filter: directed table, then random traffic.
`timescale 1ns / 100ps

module tb;
  import mcadc_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int N_CH         = CHANNEL_COUNT_DEF;
  localparam int DEPTH        = RING_DEPTH_DEF;
  localparam int SHIFT        = OVERSAMPLE_SHIFT_DEF;
  localparam int RANDOM_ITEMS = 1800;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic                ok;
    logic [MEDIAN_W-1:0] value;
  } median_res_t;

  typedef struct packed {
    logic [FUNC_W-1:0]     func;
    logic [CH_FIELD_W-1:0] ch;
    logic [RAW_W-1:0]      raw;
    logic                  typed;
    median_res_t           res;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;   // channel, raw_value, zero pad
  logic [S_TUSER_W-1:0] s_tuser = '0;   // func
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;        // median
  logic [M_TUSER_W-1:0] m_tuser;        // ready_res

  median_res_t         pending_medians[$];
  median_res_t         oldest;
  logic [MEDIAN_W-1:0] ring_mem[N_CH][DEPTH];
  int                  wr_pos[N_CH];
  int                  fill_cnt[N_CH];
  int                  mismatches = 0;
  int                  cycles = 0;
  bit                  quiet = 1'b0;

  stim_row_t dir_rows[] = '{
    '{FUNC_READ,   4'd0,  16'h0000, 1'b1, '{1'b0, 16'h0000}},
    '{FUNC_READ,   4'd15, 16'hFFFF, 1'b1, '{1'b0, 16'h0000}},
    '{FUNC_STORE,  4'd0,  16'hFFFF, 1'b0, '0},
    '{FUNC_STORE,  4'd0,  16'h0000, 1'b0, '0},
    '{FUNC_STORE,  4'd0,  16'h000F, 1'b0, '0},
    '{FUNC_STORE,  4'd0,  16'h8010, 1'b0, '0},
    '{FUNC_READ,   4'd0,  16'h0000, 1'b1, '{1'b0, 16'h0000}},
    '{FUNC_STORE,  4'd0,  16'h1230, 1'b0, '0},
    '{FUNC_READ,   4'd0,  16'h0000, 1'b0, '0},
    '{FUNC_STORE,  4'd0,  16'hFFF0, 1'b0, '0},
    '{FUNC_READ,   4'd0,  16'hFFFF, 1'b0, '0},
    '{FUNC_STORE,  4'd7,  16'hAAAA, 1'b0, '0},
    '{FUNC_STORE,  4'd8,  16'h5555, 1'b0, '0},
    '{FUNC_CLEAR,  4'd8,  16'h0000, 1'b0, '0},
    '{FUNC_UNUSED, 4'd0,  16'hFFFF, 1'b0, '0},
    '{FUNC_READ,   4'd0,  16'h0000, 1'b0, '0},
    '{FUNC_CLEAR,  4'd0,  16'h0000, 1'b0, '0},
    '{FUNC_READ,   4'd0,  16'h0000, 1'b1, '{1'b0, 16'h0000}},
    '{FUNC_STORE,  4'd15, 16'hFFFF, 1'b0, '0},
    '{FUNC_READ,   4'd8,  16'h0000, 1'b1, '{1'b0, 16'h0000}},
    '{FUNC_STORE,  4'd7,  16'h5550, 1'b0, '0},
    '{FUNC_STORE,  4'd7,  16'h0010, 1'b0, '0},
    '{FUNC_STORE,  4'd7,  16'hFFFF, 1'b0, '0},
    '{FUNC_STORE,  4'd7,  16'h7FF0, 1'b0, '0},
    '{FUNC_READ,   4'd7,  16'h0000, 1'b0, '0}
  };

  multichannel_adc_median_filter_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [MEDIAN_W-1:0] ring_middle(int ch);
    logic [MEDIAN_W-1:0] vals[DEPTH];
    logic [MEDIAN_W-1:0] t;
    vals = ring_mem[ch];
    for (int i = 0; i < DEPTH - 1; i++) begin
      for (int j = 0; j < DEPTH - 1 - i; j++) begin
        if (vals[j] > vals[j + 1]) begin
          t = vals[j];
          vals[j] = vals[j + 1];
          vals[j + 1] = t;
        end
      end
    end
    return vals[DEPTH / 2];
  endfunction

  task automatic filter_step(input logic [FUNC_W-1:0] f, input logic [CH_FIELD_W-1:0] ch,
                             input logic [RAW_W-1:0] raw, output bit has_res,
                             output median_res_t res);
    logic [MEDIAN_W-1:0] scaled;
    has_res = 1'b0;
    res = '0;
    scaled = MEDIAN_W'(raw[RAW_W-1:ADC_LSB]);
    scaled = scaled << SHIFT;
    case (f)
      FUNC_STORE: begin
        if (ch < N_CH) begin
          ring_mem[ch][wr_pos[ch]] = scaled;
          wr_pos[ch] = (wr_pos[ch] + 1) % DEPTH;
          if (fill_cnt[ch] < DEPTH) fill_cnt[ch]++;
        end
      end
      FUNC_READ: begin
        has_res = 1'b1;
        if (ch < N_CH && fill_cnt[ch] >= DEPTH) res = '{1'b1, ring_middle(ch)};
      end
      FUNC_CLEAR: begin
        if (ch < N_CH) begin
          wr_pos[ch] = 0;
          fill_cnt[ch] = 0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [CH_FIELD_W-1:0] ch,
                           input logic [RAW_W-1:0] raw, input bit typed,
                           input median_res_t typed_res);
    bit          has_res;
    median_res_t res;
    while (!quiet && $urandom_range(99) < 35) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, raw, ch};
    s_tuser  <= f;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    filter_step(f, ch, raw, has_res, res);
    if (has_res) pending_medians.push_back(typed ? typed_res : res);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_medians.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= quiet || ($urandom_range(99) >= 35);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_medians.size() == 0) begin
        $display("%0t: result expected none actual ready_res %0b median %h", $time,
                 m_tuser[0], m_tdata);
        mismatches++;
      end else begin
        oldest = pending_medians.pop_front();
        if (m_tuser[0] !== oldest.ok) begin
          $display("%0t: ready_res expected %0b actual %0b", $time, oldest.ok, m_tuser[0]);
          mismatches++;
        end
        if (m_tdata !== oldest.value) begin
          $display("%0t: median expected %h actual %h", $time, oldest.value, m_tdata);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_medians.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [FUNC_W-1:0]     f;
    logic [CH_FIELD_W-1:0] ch;
    logic [RAW_W-1:0]      raw;
    int                    sel;
    for (int c = 0; c < N_CH; c++) begin
      wr_pos[c] = 0;
      fill_cnt[c] = 0;
      for (int d = 0; d < DEPTH; d++) ring_mem[c][d] = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send_item(dir_rows[i].func, dir_rows[i].ch, dir_rows[i].raw, dir_rows[i].typed,
                dir_rows[i].res);
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= 1100 && n < 1400);
      if (n == 700) drain_results();
      sel = $urandom_range(99);
      if (sel < 55) f = FUNC_STORE;
      else if (sel < 85) f = FUNC_READ;
      else if (sel < 93) f = FUNC_CLEAR;
      else f = FUNC_UNUSED;
      ch = ($urandom_range(99) < 12) ? CH_FIELD_W'($urandom_range(15, N_CH))
                                     : CH_FIELD_W'($urandom_range(N_CH - 1, 0));
      sel = $urandom_range(9);
      raw = (sel == 0) ? 16'h0000 : (sel == 1) ? 16'hFFFF : RAW_W'($urandom);
      send_item(f, ch, raw, 1'b0, '0);
    end
    quiet = 1'b0;

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_medians.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/mcadc_pkg.sv
hdl/mcadc_ctrl.sv
hdl/mcadc_dp.sv
hdl/multichannel_adc_median_filter_core.sv
hdl/mcadc_chk.sv
tb/tb.sv
